FILE: rtl/dtz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtz_pkg;

  // pipeline depth of one daylight lane, input register to flag register
  localparam int unsigned LANE_LAT = 19;

  localparam int unsigned TIME_W = 39;
  localparam int unsigned UTC_W  = 40;
  localparam int unsigned OFF_W  = 17;

  typedef enum logic [2:0] {
    REG_STD_OFF     = 3'd0,
    REG_DST_OFF     = 3'd1,
    REG_DST_EN      = 3'd2,
    REG_START_MONTH = 3'd3,
    REG_START_WEEK  = 3'd4,
    REG_END_MONTH   = 3'd5,
    REG_END_WEEK    = 3'd6,
    REG_SWITCH_HOUR = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    STATUS_UNIQUE      = 2'd0,
    STATUS_AMBIGUOUS   = 2'd1,
    STATUS_NONEXISTENT = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [16:0] std_off;
    logic signed [16:0] dst_off;
    logic               dst_en;
    logic [3:0]         dst_start_mon;
    logic signed [3:0]  start_week;
    logic [3:0]         dst_end_mon;
    logic signed [3:0]  end_week;
    logic [4:0]         dst_hour;
  } cfg_t;

  // floor(utc / 128) + 675 * 6362943 stays positive and below 2^33
  localparam logic [32:0] DAY_BIAS = 33'd4294986525;
  // day count back to a biased day number: 6362943 - 719468 - 17 * 146097
  localparam logic [23:0] ZZ_SUB   = 24'd3159826;
  // 719468 + 17 * 146097, the era bias removed from a date's day number
  localparam logic [23:0] F_SUB    = 24'd3203117;

  // reciprocals: m = ceil(2^(n+l) / d), exact for any x below 2^n
  localparam logic [16:0] M_675_HI  = 17'(((64'd1 << 26) + 64'd674) / 64'd675);
  localparam logic [27:0] M_675_LO  = 28'(((64'd1 << 37) + 64'd674) / 64'd675);
  localparam logic [23:0] M_146097  = 24'(((64'd1 << 41) + 64'd146096) / 64'd146097);
  localparam logic [18:0] M_1460    = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] M_36524   = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] M_365     = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [9:0]  M_100     = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [15:0] M_400     = 16'(((64'd1 << 24) + 64'd399) / 64'd400);
  localparam logic [18:0] M_7_WIDE  = 19'(((64'd1 << 21) + 64'd6) / 64'd7);
  localparam logic [6:0]  M_7_SMALL = 7'(((64'd1 << 9) + 64'd6) / 64'd7);

  function automatic logic [6:0] div675_hi(input logic [15:0] x);
    logic [32:0] p;
    p = 33'(x) * 33'(M_675_HI);
    return p[32:26];
  endfunction

  function automatic logic [16:0] div675_lo(input logic [26:0] x);
    logic [54:0] p;
    p = 55'(x) * 55'(M_675_LO);
    return p[53:37];
  endfunction

  function automatic logic [5:0] div146097(input logic [22:0] x);
    logic [46:0] p;
    p = 47'(x) * 47'(M_146097);
    return p[46:41];
  endfunction

  function automatic logic [6:0] div1460(input logic [17:0] x);
    logic [36:0] p;
    p = 37'(x) * 37'(M_1460);
    return p[35:29];
  endfunction

  function automatic logic [2:0] div36524(input logic [17:0] x);
    logic [36:0] p;
    p = 37'(x) * 37'(M_36524);
    return p[36:34];
  endfunction

  function automatic logic [8:0] div365(input logic [17:0] x);
    logic [36:0] p;
    p = 37'(x) * 37'(M_365);
    return p[35:27];
  endfunction

  function automatic logic [2:0] div100(input logic [8:0] x);
    logic [18:0] p;
    p = 19'(x) * 19'(M_100);
    return p[18:16];
  endfunction

  function automatic logic [5:0] div400(input logic [14:0] x);
    logic [30:0] p;
    p = 31'(x) * 31'(M_400);
    return p[29:24];
  endfunction

  function automatic logic [14:0] div7_wide(input logic [17:0] x);
    logic [36:0] p;
    p = 37'(x) * 37'(M_7_WIDE);
    return p[35:21];
  endfunction

  function automatic logic [2:0] div7_small(input logic [5:0] x);
    logic [12:0] p;
    p = 13'(x) * 13'(M_7_SMALL);
    return p[11:9];
  endfunction

  // month register to 1..12
  function automatic logic [3:0] month_clamp(input logic [3:0] r);
    logic [3:0] m;
    m = r;
    if (r == 4'd0) m = 4'd1;
    if (r > 4'd12) m = 4'd12;
    return m;
  endfunction

  // day of a march-based year on which the month starts
  function automatic logic [8:0] month_doy(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd306;
      4'd2:    d = 9'd337;
      4'd3:    d = 9'd0;
      4'd4:    d = 9'd31;
      4'd5:    d = 9'd61;
      4'd6:    d = 9'd92;
      4'd7:    d = 9'd122;
      4'd8:    d = 9'd153;
      4'd9:    d = 9'd184;
      4'd10:   d = 9'd214;
      4'd11:   d = 9'd245;
      4'd12:   d = 9'd275;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd2:                     d = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
      default:                  d = 5'd31;
    endcase
    return d;
  endfunction

  // leap test on the year modulo 400, given as 1..400
  function automatic logic is_leap_r(input logic [9:0] r);
    return (r[1:0] == 2'b00) && (r != 10'd100) && (r != 10'd200) && (r != 10'd300);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dtz_dst_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module dtz_dst_lane (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire dtz_pkg::cfg_t      cfg_i,
  input  wire logic signed [39:0] utc_i,
  output logic                    dst_o
);
  import dtz_pkg::*;

  // per-rule settings, index 0 start and 1 end
  logic [3:0]         mon_c  [2];
  logic signed [7:0]  adj_c  [2];
  logic signed [18:0] hoff_c [2];
  logic               pos_c  [2];
  logic [16:0]        hr_sec;

  always_comb begin
    hr_sec = 17'({12'd0, cfg_i.dst_hour} * 17'd3600);
    mon_c[0] = month_clamp(cfg_i.dst_start_mon);
    mon_c[1] = month_clamp(cfg_i.dst_end_mon);
    pos_c[0] = cfg_i.start_week > 4'sd0;
    pos_c[1] = cfg_i.end_week > 4'sd0;
    adj_c[0] = pos_c[0] ? 8'sd7 * (8'(cfg_i.start_week) - 8'sd1)
                        : 8'sd7 * (8'(cfg_i.start_week) + 8'sd1);
    adj_c[1] = pos_c[1] ? 8'sd7 * (8'(cfg_i.end_week) - 8'sd1)
                        : 8'sd7 * (8'(cfg_i.end_week) + 8'sd1);
    hoff_c[0] = $signed({2'b00, hr_sec}) - 19'(cfg_i.std_off);
    hoff_c[1] = $signed({2'b00, hr_sec}) - 19'(cfg_i.dst_off);
  end

  logic signed [39:0] u_q [LANE_LAT-1];
  logic [32:0] x2_q;
  logic [6:0]  qh3_q;
  logic [15:0] xh3_q;
  logic [16:0] xl3_q;
  logic [6:0]  qh4_q;
  logic [26:0] n4_q;
  logic [22:0] zz5_q;
  logic [5:0]  era6_q;
  logic [22:0] zz6_q;
  logic [5:0]  era7_q, era8_q, era9_q, era10_q;
  logic [17:0] doe7_q, doe8_q, doe9_q, num8_q;
  logic [8:0]  yoe9_q, yoe10_q, doy10_q;
  logic [14:0] y11_q [2];
  logic [14:0] y12_q [2];
  logic [5:0]  ey12_q [2];
  logic [5:0]  ey13_q [2];
  logic [8:0]  yy13_q [2];
  logic [5:0]  ey14_q [2];
  logic [17:0] doem14_q [2];
  logic [4:0]  len14_q [2];
  logic [23:0] f15_q [2];
  logic [17:0] wn15_q [2];
  logic [14:0] q7_15_q [2];
  logic [4:0]  len15_q [2];
  logic [23:0] f16_q [2];
  logic [2:0]  w16_q [2];
  logic [4:0]  len16_q [2];
  logic [23:0] d17_q [2];
  logic signed [41:0] lim18_q [2];
  logic dst_q;

  logic [15:0] rh_wide;
  logic [17:0] t365;
  logic [14:0] base11;
  logic [2:0]  fsun   [2];
  logic [5:0]  wl_val [2];
  logic [2:0]  wl     [2];
  logic [23:0] d_d    [2];

  always_comb begin
    rh_wide = xh3_q - 16'({9'd0, qh3_q} * 16'd675);
    t365 = 18'({9'd0, yoe9_q} * 18'd365);
    base11 = 15'({9'd0, era10_q} * 15'd400) + 15'(yoe10_q) + 15'(doy10_q >= 9'd306);
    for (int k = 0; k < 2; k++) begin
      fsun[k]   = (w16_q[k] == 3'd0) ? 3'd0 : 3'd7 - w16_q[k];
      wl_val[k] = 6'(w16_q[k]) + 6'(len16_q[k]) - 6'd1;
      wl[k]     = 3'(wl_val[k] - 6'({3'd0, div7_small(wl_val[k])} * 6'd7));
      if (pos_c[k]) begin
        d_d[k] = f16_q[k] + 24'(fsun[k]) + 24'(adj_c[k]);
      end else begin
        d_d[k] = f16_q[k] + 24'(len16_q[k]) - 24'd1 - 24'(wl[k]) + 24'(adj_c[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // day number from seconds, split long division by 128 * 675
      u_q[0] <= utc_i;
      for (int i = 1; i < LANE_LAT - 1; i++) u_q[i] <= u_q[i-1];
      x2_q  <= 33'(u_q[0] >>> 7) + DAY_BIAS;
      qh3_q <= div675_hi(x2_q[32:17]);
      xh3_q <= x2_q[32:17];
      xl3_q <= x2_q[16:0];
      qh4_q <= qh3_q;
      n4_q  <= {rh_wide[9:0], xl3_q};
      zz5_q <= 23'({qh4_q, div675_lo(n4_q)} - ZZ_SUB);
      // civil year of the day number
      era6_q  <= div146097(zz5_q);
      zz6_q   <= zz5_q;
      era7_q  <= era6_q;
      doe7_q  <= 18'(zz6_q - 23'({17'd0, era6_q} * 23'd146097));
      era8_q  <= era7_q;
      doe8_q  <= doe7_q;
      num8_q  <= doe7_q - 18'(div1460(doe7_q)) + 18'(div36524(doe7_q))
                 - 18'(doe7_q == 18'd146096);
      era9_q  <= era8_q;
      doe9_q  <= doe8_q;
      yoe9_q  <= div365(num8_q);
      era10_q <= era9_q;
      yoe10_q <= yoe9_q;
      doy10_q <= 9'(doe9_q - (t365 + 18'(yoe9_q >> 2) - 18'(div100(yoe9_q))));
      // switch sunday of each rule in that year
      for (int k = 0; k < 2; k++) begin
        y11_q[k]    <= base11 - 15'(mon_c[k] <= 4'd2);
        y12_q[k]    <= y11_q[k];
        ey12_q[k]   <= div400(y11_q[k]);
        ey13_q[k]   <= ey12_q[k];
        yy13_q[k]   <= 9'(y12_q[k] - 15'({9'd0, ey12_q[k]} * 15'd400));
        ey14_q[k]   <= ey13_q[k];
        doem14_q[k] <= 18'({9'd0, yy13_q[k]} * 18'd365) + 18'(yy13_q[k] >> 2)
                       - 18'(div100(yy13_q[k])) + 18'(month_doy(mon_c[k]));
        len14_q[k]  <= month_days(mon_c[k])
                       + 5'((mon_c[k] == 4'd2) && is_leap_r(10'(yy13_q[k]) + 10'd1));
        wn15_q[k]   <= doem14_q[k] + 18'd3;
        q7_15_q[k]  <= div7_wide(doem14_q[k] + 18'd3);
        f15_q[k]    <= 24'({18'd0, ey14_q[k]} * 24'd146097) + 24'(doem14_q[k]) - F_SUB;
        len15_q[k]  <= len14_q[k];
        f16_q[k]    <= f15_q[k];
        w16_q[k]    <= 3'(wn15_q[k] - 18'({3'd0, q7_15_q[k]} * 18'd7));
        len16_q[k]  <= len15_q[k];
        d17_q[k]    <= d_d[k];
        lim18_q[k]  <= $signed(d17_q[k]) * 42'sd86400 + 42'(hoff_c[k]);
      end
      dst_q <= cfg_i.dst_en && (42'(u_q[LANE_LAT-2]) >= lim18_q[0])
               && (42'(u_q[LANE_LAT-2]) < lim18_q[1]);
    end
  end

  assign dst_o = dst_q;

endmodule

`default_nettype wire

FILE: rtl/dst_timezone_time_conversion.sv
`timescale 1ns / 1ps
// throughput: one transaction per cycle; a full 20-stage pipeline with global stall
// on a back-pressured output, each stage holds at most one item
// reset: rst_ni async active low clears valid bits and loads the register defaults
// (offsets 0, daylight off, second sunday of march to first sunday of november, 02:00)
`default_nettype none

module dst_timezone_time_conversion (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration write channel
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_addr_i,
  input  wire logic [16:0]  cfg_data_i,
  // input stream
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [39:0]  s_axis_tdata_i,   // [38:0] time_in, [39] zero
  input  wire logic         s_axis_tuser_i,   // [0] func
  // result stream
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [95:0]       m_axis_tdata_o,   // [38:0] time_a, [77:39] time_b,
                                              // [94:78] offset_used, [95] zero
  output logic [2:0]        m_axis_tuser_o    // [0] is_daylight, [2:1] status
);
  import dtz_pkg::*;

  // configuration registers; write them only while the pipeline is empty, the block itself does not enforce it
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.std_off       <= '0;
      cfg_q.dst_off       <= '0;
      cfg_q.dst_en        <= 1'b0;
      cfg_q.dst_start_mon <= 4'd3;
      cfg_q.start_week    <= 4'sd2;
      cfg_q.dst_end_mon   <= 4'd11;
      cfg_q.end_week      <= 4'sd1;
      cfg_q.dst_hour      <= 5'd2;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_STD_OFF:     cfg_q.std_off       <= $signed(cfg_data_i);
        REG_DST_OFF:     cfg_q.dst_off       <= $signed(cfg_data_i);
        REG_DST_EN:      cfg_q.dst_en        <= cfg_data_i[0];
        REG_START_MONTH: cfg_q.dst_start_mon <= cfg_data_i[3:0];
        REG_START_WEEK:  cfg_q.start_week    <= $signed(cfg_data_i[3:0]);
        REG_END_MONTH:   cfg_q.dst_end_mon   <= cfg_data_i[3:0];
        REG_END_WEEK:    cfg_q.end_week      <= $signed(cfg_data_i[3:0]);
        REG_SWITCH_HOUR: cfg_q.dst_hour      <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances together; it stalls only when the output
  // register holds a result the sink does not take
  logic out_vld_q;
  logic en;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // the input time as seen by each lane:
  //   lane a: the utc instant itself (utc to local) or the standard candidate
  //   lane b: the daylight candidate (local to utc only)
  logic signed [TIME_W-1:0] t_in;
  logic signed [UTC_W-1:0]  utc_a, utc_b;

  assign t_in  = $signed(s_axis_tdata_i[TIME_W-1:0]);
  assign utc_b = UTC_W'(t_in) - UTC_W'(cfg_q.dst_off);
  assign utc_a = s_axis_tuser_i ? UTC_W'(t_in) - UTC_W'(cfg_q.std_off) : UTC_W'(t_in);

  logic dst_a, dst_b;

  dtz_dst_lane u_lane_a (
    .clk_i (clk_i),
    .en_i  (en),
    .cfg_i (cfg_q),
    .utc_i (utc_a),
    .dst_o (dst_a)
  );

  dtz_dst_lane u_lane_b (
    .clk_i (clk_i),
    .en_i  (en),
    .cfg_i (cfg_q),
    .utc_i (utc_b),
    .dst_o (dst_b)
  );

  // side line that keeps valid, selector and input time in step with the lanes
  logic                     vld_q  [LANE_LAT];
  logic                     func_q [LANE_LAT];
  logic signed [TIME_W-1:0] t_q    [LANE_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANE_LAT; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid_i;
      for (int i = 1; i < LANE_LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      func_q[0] <= s_axis_tuser_i;
      t_q[0]    <= t_in;
      for (int i = 1; i < LANE_LAT; i++) begin
        func_q[i] <= func_q[i-1];
        t_q[i]    <= t_q[i-1];
      end
    end
  end

  // result selection once both daylight flags are known
  logic signed [UTC_W-1:0]  t_w, c_std, c_dst, loc;
  logic signed [OFF_W-1:0]  off_sel;
  logic                     ok_std, ok_dst, same_off;
  logic [TIME_W-1:0]        time_a_d, time_b_d;
  logic [OFF_W-1:0]         off_d;
  logic                     dl_d;
  status_e                  st_d;

  always_comb begin
    t_w      = UTC_W'(t_q[LANE_LAT-1]);
    c_std    = t_w - UTC_W'(cfg_q.std_off);
    c_dst    = t_w - UTC_W'(cfg_q.dst_off);
    same_off = cfg_q.std_off == cfg_q.dst_off;
    off_sel  = dst_a ? cfg_q.dst_off : cfg_q.std_off;
    loc      = t_w + UTC_W'(off_sel);
    // a candidate holds when the offset in force at it is the one that built it
    ok_std   = !dst_a || same_off;
    ok_dst   = cfg_q.dst_en && (dst_b || same_off);
    time_a_d = '0;
    time_b_d = '0;
    off_d    = '0;
    dl_d     = 1'b0;
    st_d     = STATUS_UNIQUE;
    if (!func_q[LANE_LAT-1]) begin
      time_a_d = TIME_W'(loc);
      time_b_d = TIME_W'(loc);
      off_d    = off_sel;
      dl_d     = dst_a;
    end else if (ok_std && ok_dst && !same_off) begin
      // repeated hour at the end of daylight time, daylight candidate first
      time_a_d = TIME_W'(c_dst);
      time_b_d = TIME_W'(c_std);
      off_d    = cfg_q.dst_off;
      dl_d     = 1'b1;
      st_d     = STATUS_AMBIGUOUS;
    end else if (ok_std) begin
      time_a_d = TIME_W'(c_std);
      time_b_d = TIME_W'(c_std);
      off_d    = cfg_q.std_off;
    end else if (ok_dst) begin
      time_a_d = TIME_W'(c_dst);
      time_b_d = TIME_W'(c_dst);
      off_d    = cfg_q.dst_off;
      dl_d     = 1'b1;
    end else begin
      // skipped hour at the start of daylight time
      st_d = STATUS_NONEXISTENT;
    end
  end

  // output register
  logic [TIME_W-1:0] time_a_q, time_b_q;
  logic [OFF_W-1:0]  off_q;
  logic              dl_q;
  status_e           st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      time_a_q <= time_a_d;
      time_b_q <= time_b_d;
      off_q    <= off_d;
      dl_q     <= dl_d;
      st_q     <= st_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, off_q, time_b_q, time_a_q};
  assign m_axis_tuser_o  = {st_q, dl_q};

endmodule

`default_nettype wire

FILE: verif/dst_timezone_time_conversion_tb.sv
`timescale 1ns / 1ps

module dst_timezone_time_conversion_tb;
  import dtz_pkg::*;

  // converted time as it leaves the block
  typedef struct {
    logic signed [38:0] ta;
    logic signed [38:0] tb;
    logic signed [16:0] off;
    logic               dl;
    status_e            st;
  } conv_res_t;

  // one directed row: the phase picks the zone setup, typed rows carry their answer
  typedef struct {
    int          phase;
    logic        func;
    logic [38:0] t;
    bit          typed;
    conv_res_t   r;
  } dir_row_t;

  localparam longint MIN_T  = -64'sd62135596800;
  localparam longint SPAN_T = 64'sd315537897600;
  localparam longint MDAYS [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int     LIMIT_CYC = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_addr_i = '0;
  logic [16:0]  cfg_data_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [39:0]  s_axis_tdata_i = '0;   // [38:0] time_in, [39] zero
  logic         s_axis_tuser_i = 1'b0; // [0] func
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [95:0]  m_axis_tdata_o;        // [38:0] time_a, [77:39] time_b, [94:78] offset_used
  logic [2:0]   m_axis_tuser_o;        // [0] is_daylight, [2:1] status

  cfg_t        zone;        // shadow copy of the zone registers
  conv_res_t   conv_q[$];   // conversions still owed by the block
  int          err_cnt = 0;
  int          cyc_cnt = 0;
  bit          quiet = 1'b0; // no idling on either side while set
  dir_row_t    rows[$];

  dst_timezone_time_conversion u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // calendar arithmetic, c-style truncating division on longint
  // ---------------------------------------------------------------------------
  function automatic longint civil_days(longint y, longint m, longint d);
    longint era, yoe, doy, doe;
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic longint year_from_days(longint z);
    longint era, doe, yoe, doy, mp, m;
    z = z + 719468;
    era = (z >= 0 ? z : z - 146096) / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    m   = mp < 10 ? mp + 3 : mp - 9;
    return yoe + era * 400 + (m <= 2 ? 1 : 0);
  endfunction

  function automatic longint weekday_of(longint z);
    return ((z % 7) + 11) % 7;
  endfunction

  function automatic bit leap_year(longint y);
    return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
  endfunction

  // month register clamp: 0 acts as january, 13..15 as december
  function automatic longint mon_fix(logic [3:0] r);
    if (r == 4'd0) return 1;
    if (r > 4'd12) return 12;
    return longint'(r);
  endfunction

  // day number of the nth sunday; zero or negative counts from the last one, -1 being the last
  function automatic longint sunday_day(longint y, longint m, longint n);
    longint first, last_d, last;
    if (n > 0) begin
      first = civil_days(y, m, 1);
      return first + (7 - weekday_of(first)) % 7 + 7 * (n - 1);
    end
    last_d = MDAYS[m] + ((m == 2 && leap_year(y)) ? 1 : 0);
    last   = civil_days(y, m, last_d);
    return last - weekday_of(last) - 7 * (-n - 1);
  endfunction

  function automatic bit in_dst(longint utc);
    longint days, year, hr, a, b;
    if (!zone.dst_en) return 1'b0;
    days = utc / 86400;
    if (utc % 86400 < 0) days = days - 1;
    year = year_from_days(days);
    hr   = longint'(zone.dst_hour) * 3600;
    a = sunday_day(year, mon_fix(zone.dst_start_mon), longint'($signed(zone.start_week)))
        * 86400 + hr - longint'($signed(zone.std_off));
    b = sunday_day(year, mon_fix(zone.dst_end_mon), longint'($signed(zone.end_week)))
        * 86400 + hr - longint'($signed(zone.dst_off));
    return utc >= a && utc < b;
  endfunction

  function automatic longint offset_at(longint utc);
    return in_dst(utc) ? longint'($signed(zone.dst_off)) : longint'($signed(zone.std_off));
  endfunction

  // expected conversion of one input under the current zone
  function automatic conv_res_t convert(logic func, logic [38:0] tin);
    conv_res_t r;
    longint t, so, dof, c1, c2;
    bit d, ok1, ok2;
    t   = longint'($signed(tin));
    so  = longint'($signed(zone.std_off));
    dof = longint'($signed(zone.dst_off));
    r   = '{ta: '0, tb: '0, off: '0, dl: 1'b0, st: STATUS_UNIQUE};
    if (func == 1'b0) begin
      d     = in_dst(t);
      r.off = 17'(d ? dof : so);
      r.ta  = 39'(t + (d ? dof : so));
      r.tb  = r.ta;
      r.dl  = d;
    end else begin
      c1  = t - so;
      c2  = t - dof;
      ok1 = offset_at(c1) == so;
      ok2 = zone.dst_en && offset_at(c2) == dof;
      if (ok1 && ok2 && c1 != c2) begin
        r = '{ta: c2[38:0], tb: c1[38:0], off: dof[16:0], dl: 1'b1, st: STATUS_AMBIGUOUS};
      end else if (ok1) begin
        r = '{ta: c1[38:0], tb: c1[38:0], off: so[16:0], dl: 1'b0, st: STATUS_UNIQUE};
      end else if (ok2) begin
        r = '{ta: c2[38:0], tb: c2[38:0], off: dof[16:0], dl: 1'b1, st: STATUS_UNIQUE};
      end else begin
        r.st = STATUS_NONEXISTENT;
      end
    end
    return r;
  endfunction

  // mostly times close to a switch instant, then in-range and full-width noise
  function automatic logic [38:0] pick_time(logic func);
    int     sel;
    longint y, base, delta, t;
    sel = $urandom_range(99);
    if (sel < 60) begin
      y = $urandom_range(9999, 1);
      if ($urandom_range(1))
        base = sunday_day(y, mon_fix(zone.dst_start_mon), longint'($signed(zone.start_week)));
      else
        base = sunday_day(y, mon_fix(zone.dst_end_mon), longint'($signed(zone.end_week)));
      base  = base * 86400 + longint'(zone.dst_hour) * 3600;
      delta = longint'($urandom_range(14400)) - 7200;
      t = base + delta;
      if (func == 1'b0)
        t = t - ($urandom_range(1) ? longint'($signed(zone.dst_off))
                                   : longint'($signed(zone.std_off)));
      return t[38:0];
    end
    if (sel < 92) begin
      t = longint'({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff) % SPAN_T + MIN_T;
      return t[38:0];
    end
    return 39'({$urandom, $urandom});
  endfunction

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 7);
  endfunction

  // ---------------------------------------------------------------------------
  // configuration writes, called at a falling edge with the input stream idle
  // ---------------------------------------------------------------------------
  task automatic cfg_write(reg_idx_e idx, logic [16:0] v);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_STD_OFF:     zone.std_off       = v;
      REG_DST_OFF:     zone.dst_off       = v;
      REG_DST_EN:      zone.dst_en        = v[0];
      REG_START_MONTH: zone.dst_start_mon = v[3:0];
      REG_START_WEEK:  zone.start_week    = v[3:0];
      REG_END_MONTH:   zone.dst_end_mon   = v[3:0];
      REG_END_WEEK:    zone.end_week      = v[3:0];
      default:         zone.dst_hour      = v[4:0];
    endcase
    @(negedge clk_i);
  endtask

  // let the pipeline drain, then load a whole zone setup
  task automatic load_zone(cfg_t c);
    s_axis_tvalid_i <= 1'b0;
    while (conv_q.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
    @(negedge clk_i);
    cfg_write(REG_STD_OFF,     c.std_off);
    cfg_write(REG_DST_OFF,     c.dst_off);
    cfg_write(REG_DST_EN,      17'(c.dst_en));
    cfg_write(REG_START_MONTH, 17'(c.dst_start_mon));
    cfg_write(REG_START_WEEK,  17'(c.start_week));
    cfg_write(REG_END_MONTH,   17'(c.dst_end_mon));
    cfg_write(REG_END_WEEK,    17'(c.end_week));
    cfg_write(REG_SWITCH_HOUR, 17'(c.dst_hour));
    cfg_valid_i <= 1'b0;
  endtask

  // one input transaction; entered and left at a falling edge with tvalid possibly high
  task automatic send_item(logic func, logic [38:0] t, bit typed, conv_res_t r);
    while (idle_now()) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, t};
    s_axis_tuser_i  <= func;
    do @(posedge clk_i); while (!s_axis_tready_o);
    conv_q.push_back(typed ? r : convert(func, t));
    @(negedge clk_i);
  endtask

  function automatic void add_row(int ph, logic f, longint t, bit typed,
                                  longint ta, longint tb, longint off, logic dl, status_e st);
    dir_row_t row;
    row.phase = ph;
    row.func  = f;
    row.t     = t[38:0];
    row.typed = typed;
    row.r     = '{ta: ta[38:0], tb: tb[38:0], off: off[16:0], dl: dl, st: st};
    rows.push_back(row);
  endfunction

  function automatic cfg_t zone_of(longint so, longint dof, bit en, int sm, int sw,
                                   int em, int ew, int hr);
    cfg_t c;
    c.std_off       = so[16:0];
    c.dst_off       = dof[16:0];
    c.dst_en        = en;
    c.dst_start_mon = sm[3:0];
    c.start_week    = sw[3:0];
    c.dst_end_mon   = em[3:0];
    c.end_week      = ew[3:0];
    c.dst_hour      = hr[4:0];
    return c;
  endfunction

  function automatic cfg_t random_zone();
    longint so, dof;
    so  = longint'($urandom_range(100800)) - 50400;
    dof = ($urandom_range(1)) ? so + 3600 : longint'($urandom_range(100800)) - 50400;
    if (dof > 50400) dof = 50400;
    return zone_of(so, dof, $urandom_range(7) != 0, $urandom_range(15), $urandom_range(15),
                   $urandom_range(15), $urandom_range(15), $urandom_range(31));
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and in-order compare
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    m_axis_tready_i <= rst_ni && !idle_now();
  end

  always @(posedge clk_i) begin
    conv_res_t exp_r;
    cyc_cnt <= cyc_cnt + 1;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (conv_q.size() == 0) begin
        $error("result transaction with no conversion pending");
        err_cnt++;
      end else begin
        exp_r = conv_q.pop_front();
        if (m_axis_tdata_o[38:0] !== exp_r.ta) begin
          $error("time_a: expected %0d, got %0d", exp_r.ta, $signed(m_axis_tdata_o[38:0]));
          err_cnt++;
        end
        if (m_axis_tdata_o[77:39] !== exp_r.tb) begin
          $error("time_b: expected %0d, got %0d", exp_r.tb, $signed(m_axis_tdata_o[77:39]));
          err_cnt++;
        end
        if (m_axis_tdata_o[94:78] !== exp_r.off) begin
          $error("offset_used: expected %0d, got %0d", exp_r.off,
                 $signed(m_axis_tdata_o[94:78]));
          err_cnt++;
        end
        if (m_axis_tuser_o[0] !== exp_r.dl) begin
          $error("is_daylight: expected %0d, got %0d", exp_r.dl, m_axis_tuser_o[0]);
          err_cnt++;
        end
        if (m_axis_tuser_o[2:1] !== exp_r.st) begin
          $error("status: expected %0d, got %0d", exp_r.st, m_axis_tuser_o[2:1]);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cyc_cnt > LIMIT_CYC) begin
      $display("dst_timezone_time_conversion_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    cfg_t      us_zone;
    cfg_t      plan[8];
    conv_res_t none;
    int        cur_phase;
    logic      f;

    zone = zone_of(0, 0, 0, 3, 2, 11, 1, 2);
    none = '{ta: '0, tb: '0, off: '0, dl: 1'b0, st: STATUS_UNIQUE};
    us_zone = zone_of(-18000, -14400, 1, 3, 2, 11, 1, 2);

    // after reset the zone is plain utc: every time maps to itself
    add_row(0, 0, MIN_T, 1, MIN_T, MIN_T, 0, 0, STATUS_UNIQUE);
    add_row(0, 0, 253402300799, 1, 253402300799, 253402300799, 0, 0, STATUS_UNIQUE);
    add_row(0, 1, MIN_T, 1, MIN_T, MIN_T, 0, 0, STATUS_UNIQUE);
    add_row(0, 1, 253402300799, 1, 253402300799, 253402300799, 0, 0, STATUS_UNIQUE);
    add_row(0, 0, 0, 1, 0, 0, 0, 0, STATUS_UNIQUE);
    add_row(0, 1, -1, 1, -1, -1, 0, 0, STATUS_UNIQUE);
    // full-width extremes beyond the calendar range
    add_row(0, 0, -(64'sd1 << 38), 1, -(64'sd1 << 38), -(64'sd1 << 38), 0, 0, STATUS_UNIQUE);
    add_row(0, 1, (64'sd1 << 38) - 1, 1, (64'sd1 << 38) - 1, (64'sd1 << 38) - 1, 0, 0,
            STATUS_UNIQUE);
    // us eastern zone, 2024: switches at 07:00 utc in march and 06:00 utc in november
    add_row(1, 0, 1710053999, 0, 0, 0, 0, 0, STATUS_UNIQUE);
    add_row(1, 0, 1710054000, 0, 0, 0, 0, 0, STATUS_UNIQUE);
    add_row(1, 0, 1730613599, 0, 0, 0, 0, 0, STATUS_UNIQUE);
    add_row(1, 0, 1730613600, 0, 0, 0, 0, 0, STATUS_UNIQUE);
    // local 02:30 on the spring sunday falls in the gap
    add_row(1, 1, 1710037800, 1, 0, 0, 0, 0, STATUS_NONEXISTENT);
    // local 01:30 on the autumn sunday happens twice
    add_row(1, 1, 1730597400, 0, 0, 0, 0, 0, STATUS_UNIQUE);
    add_row(1, 1, 1720000000, 0, 0, 0, 0, 0, STATUS_UNIQUE);
    add_row(1, 1, 1700000000, 0, 0, 0, 0, 0, STATUS_UNIQUE);
    add_row(1, 0, MIN_T, 0, 0, 0, 0, 0, STATUS_UNIQUE);
    add_row(1, 1, 253402300799, 0, 0, 0, 0, 0, STATUS_UNIQUE);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    cur_phase = 0;
    foreach (rows[i]) begin
      if (rows[i].phase != cur_phase) begin
        load_zone(us_zone);
        cur_phase = rows[i].phase;
      end
      send_item(rows[i].func, rows[i].t, rows[i].typed, rows[i].r);
    end

    // random phases: us, europe, southern hemisphere (window never opens),
    // register extremes, equal offsets, daylight off, then two random zones
    plan[0] = us_zone;
    plan[1] = zone_of(3600, 7200, 1, 3, -1, 10, -1, 1);
    plan[2] = zone_of(36000, 39600, 1, 10, 1, 4, 1, 2);
    plan[3] = zone_of(-50400, 50400, 1, 0, -5, 15, 5, 31);
    plan[4] = zone_of(50400, 50400, 1, 13, 0, 1, -8, 23);
    plan[5] = zone_of(-3600, 3600, 0, 12, 7, 1, -2, 0);
    plan[6] = random_zone();
    plan[7] = random_zone();
    for (int p = 0; p < 8; p++) begin
      load_zone(plan[p]);
      quiet = (p == 1);
      for (int n = 0; n < 160; n++) begin
        if (p == 3 && n == 80) begin
          // hold the sender until the pipeline is empty
          s_axis_tvalid_i <= 1'b0;
          while (conv_q.size() != 0) @(posedge clk_i);
          @(negedge clk_i);
        end
        f = 1'($urandom_range(1));
        send_item(f, pick_time(f), 0, none);
      end
    end
    quiet = 1'b0;
    s_axis_tvalid_i <= 1'b0;

    while (conv_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("dst_timezone_time_conversion_tb: PASS");
    end else begin
      $display("dst_timezone_time_conversion_tb: FAIL");
    end
    $finish;
  end

endmodule
